FILE: design/lcbs_pkg.sv
// ----------------------------------------------------------------------------
// lcbs_pkg
// Shared sizes, opcodes and bit-search helpers for the lazy-clear bitset core.
// ----------------------------------------------------------------------------
package lcbs_pkg;

    localparam int WORD_BITS       = 64;
    localparam int WORDS_PER_BLOCK = 4;
    localparam int MAX_BLOCKS      = 4;
    localparam int BLOCK_BITS      = WORD_BITS * WORDS_PER_BLOCK;

    localparam int IDX_W   = 10;
    localparam int BIT_W   = $clog2(WORD_BITS);
    localparam int WSEL_W  = $clog2(WORDS_PER_BLOCK);
    localparam int OFF_W   = BIT_W + WSEL_W;
    localparam int BLK_W   = IDX_W - OFF_W;
    localparam int PTR_W   = BLK_W + 1;
    localparam int CNT_W   = $clog2(WORDS_PER_BLOCK + 1);
    localparam int BIU_W   = 3;
    localparam int FUNC_W  = 2;
    localparam int TDATA_W = 16;

    localparam logic [FUNC_W-1:0] FUNC_FLIP  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FIND  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NONE  = 2'd3;

    // {nonzero, lowest set bit}
    function automatic logic [BIT_W:0] word_low(input logic [WORD_BITS-1:0] v);
        logic [BIT_W:0] r;
        r = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i])
            begin
                r = {1'b1, BIT_W'(i)};
            end
        end
        return r;
    endfunction

    // {nonzero, word select, bit} of the lowest set bit in one block
    function automatic logic [OFF_W:0] block_low(input logic [BLOCK_BITS-1:0] v);
        logic [BIT_W:0] w_r;
        logic [OFF_W:0] r;
        r = '0;
        for (int w = WORDS_PER_BLOCK - 1; w >= 0; w--) begin
            w_r = word_low(v[w*WORD_BITS +: WORD_BITS]);
            if (w_r[BIT_W])
            begin
                r = {1'b1, WSEL_W'(w), w_r[BIT_W-1:0]};
            end
        end
        return r;
    endfunction

endpackage

FILE: design/lazy_clear_bitset_scan_core.sv
// ----------------------------------------------------------------------------
// lazy_clear_bitset_scan_core
// Block-organized membership bitmap with lazy clear and find-next-set scan.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake            contents (low bit first)
//  s_*       in   s_tvalid/s_tready    tdata: func[1:0], index[11:2], 0[15:12]
//  m_*       out  m_tvalid/m_tready    tdata: found[0], position[10:1],
//                                             status[11], 0[15:12]
//  cfg_*     in   cfg_we               cfg_wdata: blocks_in_use[2:0]
//
//  Clear, unused func and range errors go straight to the result; a flip
//  reads the row, modifies one word and writes it back. A find walks the
//  blocks from the start block: a stale or empty block is skipped without a
//  row read, a scanned block is read and checked, and the scan ends past the
//  last block in use. The row memory has a single read port.
//  One item is in work at a time; s_tready is high again once its result is
//  loaded into the output register, so the next transfer overlaps a stalled
//  result. Reset (async, rst_n low) marks every block stale, which reads as
//  empty, so the row memory needs no clearing pass.
//
module lazy_clear_bitset_scan_core
    import lcbs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // func[1:0], index[11:2]
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // found[0], position[10:1], status[11]
    input  logic               cfg_we,
    input  logic [BIU_W-1:0]   cfg_wdata  // blocks_in_use
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FLIP  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_CHECK = 3'd3;
    localparam logic [2:0] ST_RESP  = 3'd4;

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WORDS_PER_BLOCK);
    localparam logic [BIU_W-1:0] BLK_MAX  = BIU_W'(MAX_BLOCKS);

    // control state
    logic [2:0]            state_reg, state_next;
    logic [MAX_BLOCKS-1:0] stale_reg, stale_next;     // lazy-clear marks
    logic [CNT_W-1:0]      cnt_reg  [MAX_BLOCKS];     // empty words per block
    logic [CNT_W-1:0]      cnt_next [MAX_BLOCKS];
    logic [BIU_W-1:0]      biu_reg, biu_next;
    logic                  m_tvalid_reg, m_tvalid_next;

    // payload
    logic [BLK_W-1:0]      op_blk_reg, op_blk_next;
    logic [OFF_W-1:0]      op_off_reg, op_off_next;
    logic [PTR_W-1:0]      ptr_reg, ptr_next;
    logic                  first_reg, first_next;
    logic                  res_found_reg, res_found_next;
    logic [IDX_W-1:0]      res_pos_reg, res_pos_next;
    logic                  res_status_reg, res_status_next;
    logic [TDATA_W-1:0]    m_tdata_reg, m_tdata_next;

    // row memory: one row per block, read data registered
    logic [BLOCK_BITS-1:0] mem [MAX_BLOCKS];
    logic [BLOCK_BITS-1:0] rdata_reg;
    logic [BLK_W-1:0]      rd_addr;
    logic                  mem_we;
    logic [BLOCK_BITS-1:0] new_row;

    // decode
    logic [FUNC_W-1:0]     in_func;
    logic [IDX_W-1:0]      in_idx;
    logic [BLK_W-1:0]      in_blk;
    logic [BIU_W-1:0]      nblk;
    logic                  in_range;
    logic                  accept;
    logic                  out_free;

    // flip datapath
    logic                  op_stale;
    logic [BLOCK_BITS-1:0] base_row;
    logic [WSEL_W-1:0]     wsel;
    logic [WORD_BITS-1:0]  old_word;
    logic [WORD_BITS-1:0]  new_word;
    logic [CNT_W-1:0]      base_cnt;
    logic [CNT_W-1:0]      new_cnt;

    // scan datapath
    logic [BLK_W-1:0]      ptr_blk;
    logic                  ptr_live;
    logic                  ptr_skip;
    logic [BLOCK_BITS-1:0] masked;
    logic [OFF_W:0]        low;

    assign in_func  = s_tdata[FUNC_W-1:0];
    assign in_idx   = s_tdata[FUNC_W +: IDX_W];
    assign in_blk   = in_idx[IDX_W-1 -: BLK_W];
    assign nblk     = (biu_reg > BLK_MAX) ? BLK_MAX : biu_reg;
    assign in_range = BIU_W'(in_blk) < nblk;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // read-modify-write of one word for a flip; a stale row counts as zero
    assign op_stale = stale_reg[op_blk_reg];
    assign base_row = op_stale ? '0 : rdata_reg;
    assign wsel     = op_off_reg[OFF_W-1:BIT_W];
    assign old_word = base_row[wsel*WORD_BITS +: WORD_BITS];
    assign new_word = old_word ^ (WORD_BITS'(1) << op_off_reg[BIT_W-1:0]);
    assign base_cnt = op_stale ? CNT_FULL : cnt_reg[op_blk_reg];

    always_comb
    begin
        new_row = base_row;
        new_row[wsel*WORD_BITS +: WORD_BITS] = new_word;
    end

    always_comb
    begin
        if (old_word == '0)
        begin
            new_cnt = base_cnt - CNT_W'(1);
        end
        else if (new_word == '0)
        begin
            new_cnt = base_cnt + CNT_W'(1);
        end
        else
        begin
            new_cnt = base_cnt;
        end
    end

    // scan: a block is skipped without a read when stale or all words empty
    assign ptr_blk  = ptr_reg[BLK_W-1:0];
    assign ptr_live = BIU_W'(ptr_reg) < nblk;
    assign ptr_skip = stale_reg[ptr_blk] || (cnt_reg[ptr_blk] == CNT_FULL);

    // first block of a find ignores bits below the start offset
    always_comb
    begin
        for (int i = 0; i < BLOCK_BITS; i++) begin
            masked[i] = rdata_reg[i] && (!first_reg || (OFF_W'(i) >= op_off_reg));
        end
    end

    assign low = block_low(masked);

    assign rd_addr = (state_reg == ST_IDLE) ? in_blk : ptr_blk;
    assign mem_we  = (state_reg == ST_FLIP);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[op_blk_reg] <= new_row;
        end
        rdata_reg <= mem[rd_addr];
    end

    // next-state logic
    always_comb
    begin
        state_next      = state_reg;
        stale_next      = stale_reg;
        cnt_next        = cnt_reg;
        biu_next        = biu_reg;
        op_blk_next     = op_blk_reg;
        op_off_next     = op_off_reg;
        ptr_next        = ptr_reg;
        first_next      = first_reg;
        res_found_next  = res_found_reg;
        res_pos_next    = res_pos_reg;
        res_status_next = res_status_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;

        if (cfg_we)
        begin
            biu_next = cfg_wdata;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_blk_next     = in_blk;
                    op_off_next     = in_idx[OFF_W-1:0];
                    ptr_next        = PTR_W'(in_blk);
                    first_next      = 1'b1;
                    res_found_next  = 1'b0;
                    res_pos_next    = '0;
                    res_status_next = 1'b0;
                    state_next      = ST_RESP;
                    case (in_func)
                        FUNC_CLEAR:
                        begin
                            stale_next = '1;
                        end
                        FUNC_FLIP:
                        begin
                            if (in_range)
                            begin
                                state_next = ST_FLIP;
                            end
                            else
                            begin
                                res_status_next = 1'b1;
                            end
                        end
                        FUNC_FIND:
                        begin
                            if (in_range)
                            begin
                                state_next = ST_SCAN;
                            end
                            else
                            begin
                                res_status_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            // unused code: plain zero result
                        end
                    endcase
                end
            end
            ST_FLIP:
            begin
                stale_next[op_blk_reg] = 1'b0;
                cnt_next[op_blk_reg]   = new_cnt;
                state_next             = ST_RESP;
            end
            ST_SCAN:
            begin
                if (!ptr_live)
                begin
                    state_next = ST_RESP;
                end
                else if (ptr_skip)
                begin
                    ptr_next   = ptr_reg + PTR_W'(1);
                    first_next = 1'b0;
                end
                else
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (low[OFF_W])
                begin
                    res_found_next = 1'b1;
                    res_pos_next   = {ptr_blk, low[OFF_W-1:0]};
                    state_next     = ST_RESP;
                end
                else
                begin
                    ptr_next   = ptr_reg + PTR_W'(1);
                    first_next = 1'b0;
                    state_next = ST_SCAN;
                end
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{(TDATA_W - IDX_W - 2){1'b0}},
                                     res_status_reg, res_pos_reg, res_found_reg};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            stale_reg    <= '1;
            biu_reg      <= BIU_W'(4);
            m_tvalid_reg <= 1'b0;
            for (int b = 0; b < MAX_BLOCKS; b++) begin
                cnt_reg[b] <= CNT_FULL;
            end
        end
        else
        begin
            state_reg    <= state_next;
            stale_reg    <= stale_next;
            biu_reg      <= biu_next;
            m_tvalid_reg <= m_tvalid_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_blk_reg     <= op_blk_next;
        op_off_reg     <= op_off_next;
        ptr_reg        <= ptr_next;
        first_reg      <= first_next;
        res_found_reg  <= res_found_next;
        res_pos_reg    <= res_pos_next;
        res_status_reg <= res_status_next;
        m_tdata_reg    <= m_tdata_next;
    end

    // a scanned row is always a live, in-range block
    a_check_live: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CHECK |-> !stale_reg[ptr_blk] && ptr_live)
        else $error("scan read a stale or out-of-range block");

    // a flip always leaves its block unmarked
    a_flip_unmarks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FLIP |=> !stale_reg[$past(op_blk_reg)])
        else $error("flipped block still marked stale");

    // a finished result waits while the output register is held
    a_resp_holds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RESP && m_tvalid_reg && !m_tready |=> state_reg == ST_RESP)
        else $error("result dropped while output stalled");

    // empty-word count never exceeds the words in a block
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FLIP && !op_stale |-> base_cnt <= CNT_FULL)
        else $error("empty word count out of range");

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for lazy_clear_bitset_scan_core. A short table of
// directed transfers (with hand-written answers where they are obvious) is
// followed by random flip/find/clear traffic under several block counts and
// idle patterns. Other results are checked against an in-bench bitmap model.
// ----------------------------------------------------------------------------
module testbench;
    import lcbs_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_ITEMS  = 225;
    localparam int ZERO_ITEMS   = 50;     // block count 0: every flip/find errors
    localparam int HOLD_CYCLES  = 300;    // long output back-pressure stretch
    localparam int DRAIN_CYCLES = 16;     // pause after the last result

    typedef struct {
        bit       found;
        bit [9:0] position;
        bit       status;
    } bitset_result_t;

    // one directed row: either a register write or a transfer
    typedef struct {
        bit             is_cfg;
        bit [BIU_W-1:0] cfg_val;
        logic [1:0]     func;
        bit [9:0]       index;
        bit             known;
        bitset_result_t want;
    } stim_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata = '0;   // func[1:0], index[11:2]
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;        // found[0], position[10:1], status[11]
    logic               cfg_we = 1'b0;
    logic [BIU_W-1:0]   cfg_wdata = '0;

    // bitmap model state
    bit [WORD_BITS-1:0] words [MAX_BLOCKS*WORDS_PER_BLOCK];
    bit                 stale [MAX_BLOCKS];
    int                 empties [MAX_BLOCKS];
    bit [BIU_W-1:0]     blocks_cfg;

    bitset_result_t results_due [$];
    stim_row_t      dir_rows [$];

    int send_pct = 0;
    int recv_pct = 0;
    int hold_len = 0;
    int fail_cnt = 0;
    int n_items = 0;
    int finds_hit = 0;
    int range_errs = 0;

    lazy_clear_bitset_scan_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Applies one command to the bitmap model and returns its result.
    function automatic bitset_result_t bitset_apply(logic [1:0] func, bit [9:0] idx);
        bitset_result_t res;
        int eff, blk, off, wsel, b, w, w0, k, lsb;
        bit [WORD_BITS-1:0] old_w, new_w, v;
        res = '{found: 1'b0, position: 10'd0, status: 1'b0};
        eff = (blocks_cfg > MAX_BLOCKS) ? MAX_BLOCKS : int'(blocks_cfg);
        blk = idx / BLOCK_BITS;
        off = idx % BLOCK_BITS;
        if (func == FUNC_CLEAR)
        begin
            for (b = 0; b < MAX_BLOCKS; b++)
                stale[b] = 1'b1;
            return res;
        end
        if (func == FUNC_NONE)
            return res;
        if (blk >= eff)
        begin
            res.status = 1'b1;
            return res;
        end
        if (func == FUNC_FLIP)
        begin
            wsel = off / WORD_BITS;
            // a marked block is wiped on its first touch
            if (stale[blk])
            begin
                for (w = 0; w < WORDS_PER_BLOCK; w++)
                    words[blk*WORDS_PER_BLOCK + w] = '0;
                stale[blk] = 1'b0;
                empties[blk] = WORDS_PER_BLOCK;
            end
            old_w = words[blk*WORDS_PER_BLOCK + wsel];
            new_w = old_w ^ (64'd1 << (off % WORD_BITS));
            words[blk*WORDS_PER_BLOCK + wsel] = new_w;
            if (old_w == 0 && new_w != 0)
                empties[blk]--;
            else if (old_w != 0 && new_w == 0)
                empties[blk]++;
            return res;
        end
        // find: lowest set bit at or after idx, marked/empty blocks skipped
        for (b = blk; b < eff; b++)
        begin
            if (!(stale[b] || empties[b] == WORDS_PER_BLOCK))
            begin
                w0 = (b == blk) ? off / WORD_BITS : 0;
                for (w = w0; w < WORDS_PER_BLOCK; w++)
                begin
                    v = words[b*WORDS_PER_BLOCK + w];
                    if (b == blk && w == w0)
                        v &= ~((64'd1 << (off % WORD_BITS)) - 64'd1);
                    if (v != 0)
                    begin
                        lsb = 0;
                        for (k = WORD_BITS - 1; k >= 0; k--)
                            if (v[k])
                                lsb = k;
                        res.found = 1'b1;
                        res.position = 10'(b*BLOCK_BITS + w*WORD_BITS + lsb);
                        return res;
                    end
                end
            end
        end
        return res;
    endfunction

    function automatic stim_row_t row_cfg(bit [BIU_W-1:0] v);
        stim_row_t r;
        r = '{is_cfg: 1'b1, cfg_val: v, func: FUNC_NONE, index: 10'd0, known: 1'b0,
              want: '{found: 1'b0, position: 10'd0, status: 1'b0}};
        return r;
    endfunction

    function automatic stim_row_t row_item(logic [1:0] f, bit [9:0] ix);
        stim_row_t r;
        r = '{is_cfg: 1'b0, cfg_val: '0, func: f, index: ix, known: 1'b0,
              want: '{found: 1'b0, position: 10'd0, status: 1'b0}};
        return r;
    endfunction

    function automatic stim_row_t row_known(logic [1:0] f, bit [9:0] ix,
                                            bit fnd, bit [9:0] pos, bit st);
        stim_row_t r;
        r = '{is_cfg: 1'b0, cfg_val: '0, func: f, index: ix, known: 1'b1,
              want: '{found: fnd, position: pos, status: st}};
        return r;
    endfunction

    // Offers one transfer, waits for it to be taken and queues its result.
    // Called at a rising edge; valid stays high into the next call when no
    // idle cycle is drawn, so it is assigned only once per time step.
    task automatic send_cmd(logic [1:0] f, bit [9:0] ix, bit known, bitset_result_t want);
        bitset_result_t res;
        while ($urandom_range(99) < send_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_W'({ix, f});
        do
            @(posedge clk);
        while (!s_tready);
        res = bitset_apply(f, ix);
        n_items++;
        if (res.found)
            finds_hit++;
        if (res.status)
            range_errs++;
        results_due.push_back(known ? want : res);
    endtask

    // Register write with the core drained; only one item is ever in work,
    // so the last result marks it idle, plus a short settling pause.
    task automatic program_blocks(bit [BIU_W-1:0] v);
        s_tvalid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        blocks_cfg = v;
    endtask

    // Output side: checks every transfer and drives ready, with an optional
    // long hold requested by the stimulus.
    initial
    begin
        int hold_cnt;
        bitset_result_t exp_r;
        hold_cnt = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                if (results_due.size() == 0)
                begin
                    $error("result with nothing expected: tdata=%h", m_tdata);
                    fail_cnt++;
                end
                else
                begin
                    exp_r = results_due.pop_front();
                    if (m_tdata[0] !== exp_r.found)
                    begin
                        $error("found: expected %0d, actual %0d", exp_r.found, m_tdata[0]);
                        fail_cnt++;
                    end
                    if (m_tdata[10:1] !== exp_r.position)
                    begin
                        $error("position: expected %0d, actual %0d",
                               exp_r.position, m_tdata[10:1]);
                        fail_cnt++;
                    end
                    if (m_tdata[11] !== exp_r.status)
                    begin
                        $error("status: expected %0d, actual %0d", exp_r.status, m_tdata[11]);
                        fail_cnt++;
                    end
                end
            end
            if (hold_len > 0)
            begin
                hold_cnt = hold_len;
                hold_len = 0;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_pct);
        end
    end

    initial
    begin
        #(2 * CLK_HALF * 400000);
        $display("timeout with %0d results outstanding", results_due.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        bit [BIU_W-1:0] phase_cfg [NUM_PHASES];
        int p, i, r, eff, hot, n_phase;
        logic [1:0] f;
        bit [9:0] ix;
        stim_row_t row;
        bitset_result_t none_r;

        phase_cfg = '{3'd4, 3'd1, 3'd2, 3'd7, 3'd3, 3'd0, 3'd6, 3'd5};
        none_r = '{found: 1'b0, position: 10'd0, status: 1'b0};
        for (i = 0; i < MAX_BLOCKS*WORDS_PER_BLOCK; i++)
            words[i] = '0;
        for (i = 0; i < MAX_BLOCKS; i++)
        begin
            stale[i] = 1'b0;
            empties[i] = WORDS_PER_BLOCK;
        end
        blocks_cfg = 3'd4;

        // directed table, block count at its reset value of 4
        dir_rows.push_back(row_known(FUNC_FIND,  10'd0,    0, 10'd0,    0));  // empty map
        dir_rows.push_back(row_known(FUNC_FIND,  10'd1023, 0, 10'd0,    0));
        dir_rows.push_back(row_known(FUNC_FLIP,  10'd0,    0, 10'd0,    0));
        dir_rows.push_back(row_known(FUNC_FLIP,  10'd1023, 0, 10'd0,    0));
        dir_rows.push_back(row_known(FUNC_FIND,  10'd0,    1, 10'd0,    0));
        dir_rows.push_back(row_known(FUNC_FIND,  10'd1,    1, 10'd1023, 0));  // skips 2 blocks
        dir_rows.push_back(row_known(FUNC_NONE,  10'd1023, 0, 10'd0,    0));  // unused func
        dir_rows.push_back(row_known(FUNC_FIND,  10'd1023, 1, 10'd1023, 0));
        dir_rows.push_back(row_item (FUNC_FLIP,  10'd300));
        dir_rows.push_back(row_item (FUNC_FIND,  10'd1));
        dir_rows.push_back(row_known(FUNC_CLEAR, 10'd517,  0, 10'd0,    0));  // index ignored
        dir_rows.push_back(row_known(FUNC_FIND,  10'd0,    0, 10'd0,    0));  // all marked
        dir_rows.push_back(row_item (FUNC_FLIP,  10'd700));                  // wipes block 2
        dir_rows.push_back(row_item (FUNC_FIND,  10'd0));
        dir_rows.push_back(row_item (FUNC_FLIP,  10'd700));                  // word empties again
        dir_rows.push_back(row_item (FUNC_FIND,  10'd0));
        dir_rows.push_back(row_item (FUNC_FLIP,  10'd63));
        dir_rows.push_back(row_item (FUNC_FLIP,  10'd64));
        dir_rows.push_back(row_item (FUNC_FIND,  10'd64));
        dir_rows.push_back(row_cfg(3'd1));
        dir_rows.push_back(row_known(FUNC_FLIP,  10'd256,  0, 10'd0,    1));  // past last block
        dir_rows.push_back(row_item (FUNC_FIND,  10'd65));                   // stops at block 1
        dir_rows.push_back(row_cfg(3'd0));
        dir_rows.push_back(row_known(FUNC_FIND,  10'd0,    0, 10'd0,    1));  // no blocks at all
        dir_rows.push_back(row_known(FUNC_FLIP,  10'd0,    0, 10'd0,    1));
        dir_rows.push_back(row_cfg(3'd7));                                   // clamps to 4
        dir_rows.push_back(row_item (FUNC_FLIP,  10'd1000));
        dir_rows.push_back(row_item (FUNC_FIND,  10'd65));

        // reset held low, then released at a rising edge
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[k])
        begin
            row = dir_rows[k];
            if (row.is_cfg)
                program_blocks(row.cfg_val);
            else
                send_cmd(row.func, row.index, row.known, row.want);
        end

        // random phases: each with its own block count and idle pattern
        for (p = 0; p < NUM_PHASES; p++)
        begin
            program_blocks(phase_cfg[p]);
            case (p % 4)
                0: begin send_pct = 0;  recv_pct = 0;  end
                1: begin send_pct = 67; recv_pct = 0;  end
                2: begin send_pct = 0;  recv_pct = 67; end
                default: begin send_pct = 7; recv_pct = 7; end
            endcase
            eff = (blocks_cfg > MAX_BLOCKS) ? MAX_BLOCKS : int'(blocks_cfg);
            hot = (eff > 0) ? $urandom_range(eff - 1) : 0;
            n_phase = (eff == 0) ? ZERO_ITEMS : PHASE_ITEMS;
            for (i = 0; i < n_phase; i++)
            begin
                // back-pressure burst while input keeps streaming
                if (p == 0 && i == 100)
                    hold_len = HOLD_CYCLES;
                r = $urandom_range(99);
                if (r < 50)
                    f = FUNC_FLIP;
                else if (r < 92)
                    f = FUNC_FIND;
                else if (r < 96)
                    f = FUNC_CLEAR;
                else
                    f = FUNC_NONE;
                // mostly in range, a hot block for dense runs, some strays
                if (eff == 0 || $urandom_range(9) == 0)
                    ix = 10'($urandom_range(1023));
                else if ($urandom_range(3) == 0)
                    ix = 10'(hot*BLOCK_BITS + $urandom_range(BLOCK_BITS - 1));
                else
                    ix = 10'($urandom_range(eff*BLOCK_BITS - 1));
                send_cmd(f, ix, 1'b0, none_r);
            end
        end

        // drain
        s_tvalid <= 1'b0;
        send_pct = 0;
        recv_pct = 0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d commands over %0d block-count settings and 4 idle patterns;",
                 n_items, NUM_PHASES);
        $display("%0d finds located a bit, %0d commands hit the range check.",
                 finds_hit, range_errs);
        if (fail_cnt == 0 && results_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
